@@ design/wrapped_angle_profile_interp_top_assert.svh @@
// Assertion macros for the checker file of this block.
`ifndef WRAPPED_ANGLE_PROFILE_INTERP_TOP_ASSERT_SVH
`define WRAPPED_ANGLE_PROFILE_INTERP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WAPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wapi: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WAPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wapi: assertion failed");

`endif

@@ design/wapi_pkg.sv @@
`default_nettype none

package wapi_pkg;

  // Field widths
  localparam int DISP_W    = 32;
  localparam int ANG_W     = 16;
  localparam int IDX_IN_W  = 4;
  localparam int CNT_W     = 5;
  localparam int KIND_W    = 2;
  localparam int EXT_W     = ANG_W + 2;
  // Magnitude of a wrapped angle difference fits in 15 bits (at most pi)
  localparam int MAG_W     = 15;
  localparam int PROD_W    = MAG_W + DISP_W;
  localparam int ENTRY_W   = DISP_W + ANG_W;

  // Stream payload layout
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 16;
  localparam int OFS_IDX   = 0;
  localparam int OFS_BP    = OFS_IDX + IDX_IN_W;
  localparam int OFS_ANG   = OFS_BP + DISP_W;
  localparam int OFS_QRY   = OFS_ANG + ANG_W;

  localparam int MAX_ENTRIES_DEF = 16;

  // Angle constants in Q2.13
  localparam logic signed [EXT_W-1:0] PI_Q     = 18'sd25736;
  localparam logic signed [EXT_W-1:0] TWO_PI_Q = 18'sd51472;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_INTERP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEFORE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_AFTER  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FEW    = 2'd3;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DISP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MAG_W-1:0]  quo;
    logic [DISP_W-1:0] rem;
  } div_rsp_t;

  // Fold an angle back into [-pi, pi] with one step of 2*pi
  function automatic logic signed [EXT_W-1:0] wrap_pi(input logic signed [EXT_W-1:0] a);
    logic signed [EXT_W-1:0] r;
    r = a;
    if (a > PI_Q) begin
      r = a - TWO_PI_Q;
    end else if (a < -PI_Q) begin
      r = a + TWO_PI_Q;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/wapi_table.sv @@
`default_nettype none

module wapi_table
  import wapi_pkg::*;
#(
  parameter int Depth = MAX_ENTRIES_DEF,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               wr_en_i,
  input  wire logic [AW-1:0]      wr_addr_i,
  input  wire logic [ENTRY_W-1:0] wr_data_i,
  input  wire logic [AW-1:0]      rd_addr_i,
  output logic      [ENTRY_W-1:0] rd_data_o
);

  // Breakpoint in the upper bits, heading in the lower bits
  logic [ENTRY_W-1:0] mem_q [Depth];
  logic [ENTRY_W-1:0] rd_data_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ design/wapi_div.sv @@
`default_nettype none

module wapi_div
  import wapi_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int STEP_W = $clog2(MAG_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DISP_W-1:0] rem_q;
  logic [MAG_W-1:0]  low_q;
  logic [MAG_W-1:0]  quo_q;
  logic [DISP_W-1:0] dsr_q;

  logic [DISP_W:0]   rem_sh;
  logic [DISP_W+1:0] diff;
  logic              ge;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    rem_sh = {rem_q, low_q[MAG_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
    ge     = ~diff[DISP_W+1];
  end

  // Sequence the shift-subtract steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder, remaining dividend bits and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[PROD_W-1:MAG_W];
      low_q <= req_i.dividend[MAG_W-1:0];
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DISP_W-1:0] : rem_sh[DISP_W-1:0];
      low_q <= {low_q[MAG_W-2:0], 1'b0};
      quo_q <= {quo_q[MAG_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ design/wrapped_angle_profile_interp_top.sv @@
// Write item: taken with no result; the block stays ready. Query: with fewer than two entries
// the heading is zero; a query below the first or at/after the last breakpoint gets that end's
// heading; else one entry is scanned per cycle up to the first breakpoint above the query, then
// a 15-step divider runs, skipped on a non-positive spacing (the lower heading is returned).
// One query at a time; a stalled result holds the block in its output step.
// Reset (asynchronous, active low) clears the entry count and all control; table undefined.
`default_nettype none

module wrapped_angle_profile_interp_top
  import wapi_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Entry count register
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CNT_W-1:0]     cfg_data_i,
  // Requests
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // entry_index[3:0], entry_disp[35:4], entry_angle[51:36], query_disp[83:52], zeros
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type[0]
  input  wire logic                 s_axis_tuser,
  // Results
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // heading[15:0]
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // result_kind[1:0]
  output logic [KIND_W-1:0]         m_axis_tuser
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_W0   = 4'd1;
  localparam logic [3:0] ST_CMP0 = 4'd2;
  localparam logic [3:0] ST_CMPL = 4'd3;
  localparam logic [3:0] ST_SCAN = 4'd4;
  localparam logic [3:0] ST_PREP = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_ADD  = 4'd8;
  localparam logic [3:0] ST_PUSH = 4'd9;

  logic [3:0]               state_q, state_d;
  logic [CNT_W-1:0]         count_q;
  logic [AW-1:0]            ra_q, ra_d;
  logic signed [DISP_W-1:0] qry_q, qry_d;
  logic signed [DISP_W-1:0] bp_lo_q, bp_lo_d, bp_hi_q, bp_hi_d;
  logic signed [ANG_W-1:0]  a_lo_q, a_lo_d, a_hi_q, a_hi_d;
  logic [DISP_W-1:0]        dd_q, dd_d, off_q, off_d;
  logic [MAG_W-1:0]         dmag_q, dmag_d;
  logic                     dneg_q, dneg_d;
  logic [MAG_W:0]           tmag_q, tmag_d;
  logic [ANG_W-1:0]         res_h_q, res_h_d;
  logic [KIND_W-1:0]        res_k_q, res_k_d;
  logic                     m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]     m_data_q, m_data_d;
  logic [KIND_W-1:0]        m_kind_q, m_kind_d;

  logic                     s_acc;
  logic [IDX_IN_W-1:0]      in_idx;
  logic [DISP_W-1:0]        in_bp;
  logic [ANG_W-1:0]         in_ang;
  logic [DISP_W-1:0]        in_qry;
  logic [CNT_W-1:0]         n_eff;
  logic [AW-1:0]            last_idx;
  logic                     wr_en;
  logic [ENTRY_W-1:0]       rd_data;
  logic signed [DISP_W-1:0] rd_bp;
  logic signed [ANG_W-1:0]  rd_ang;
  logic signed [DISP_W:0]   dd_full;
  logic signed [DISP_W:0]   off_full;
  logic signed [EXT_W-1:0]  da;
  logic signed [EXT_W-1:0]  term;
  logic signed [EXT_W-1:0]  hsum;
  logic signed [EXT_W-1:0]  hwrap;
  logic                     rnd_up;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Unpack the request payload
  assign s_acc  = s_axis_tvalid & s_axis_tready;
  assign in_idx = s_axis_tdata[OFS_IDX +: IDX_IN_W];
  assign in_bp  = s_axis_tdata[OFS_BP  +: DISP_W];
  assign in_ang = s_axis_tdata[OFS_ANG +: ANG_W];
  assign in_qry = s_axis_tdata[OFS_QRY +: DISP_W];

  // Saturate the entry count to the table depth
  assign n_eff    = (int'(count_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : count_q;
  assign last_idx = AW'(n_eff - CNT_W'(1));

  // Drop writes to slots beyond the table
  assign wr_en = s_acc && (s_axis_tuser == REQ_WRITE) && (int'(in_idx) < MAX_ENTRIES);

  wapi_table #(
    .Depth(MAX_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(AW'(in_idx)),
    .wr_data_i({in_bp, in_ang}),
    .rd_addr_i(ra_q),
    .rd_data_o(rd_data)
  );

  assign rd_bp  = $signed(rd_data[ENTRY_W-1:ANG_W]);
  assign rd_ang = $signed(rd_data[ANG_W-1:0]);

  // Divider: |d| * offset over the breakpoint spacing
  always_comb begin
    div_req.start    = (state_q == ST_MUL);
    div_req.dividend = PROD_W'({{DISP_W{1'b0}}, dmag_q} * {{MAG_W{1'b0}}, off_q});
    div_req.divisor  = dd_q;
  end

  wapi_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Spacing, offset, angle difference, rounding and final sum
  always_comb begin
    dd_full  = {bp_hi_q[DISP_W-1], bp_hi_q} - {bp_lo_q[DISP_W-1], bp_lo_q};
    off_full = {qry_q[DISP_W-1], qry_q} - {bp_lo_q[DISP_W-1], bp_lo_q};
    da       = wrap_pi(EXT_W'(a_hi_q) - EXT_W'(a_lo_q));
    rnd_up   = ({div_rsp.rem, 1'b0} >= {1'b0, dd_q});
    term     = dneg_q ? -$signed({2'b00, tmag_q}) : $signed({2'b00, tmag_q});
    hsum     = EXT_W'(a_lo_q) + term;
    hwrap    = wrap_pi(hsum);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ra_d      = ra_q;
    qry_d     = qry_q;
    bp_lo_d   = bp_lo_q;
    a_lo_d    = a_lo_q;
    bp_hi_d   = bp_hi_q;
    a_hi_d    = a_hi_q;
    dd_d      = dd_q;
    off_d     = off_q;
    dmag_d    = dmag_q;
    dneg_d    = dneg_q;
    tmag_d    = tmag_q;
    res_h_d   = res_h_q;
    res_k_d   = res_k_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_kind_d  = m_kind_q;

    // Retire a taken result
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc && (s_axis_tuser == REQ_QUERY)) begin
          qry_d = $signed(in_qry);
          ra_d  = '0;
          if (n_eff < CNT_W'(2)) begin
            res_h_d = '0;
            res_k_d = KIND_FEW;
            state_d = ST_PUSH;
          end else begin
            state_d = ST_W0;
          end
        end
      end
      ST_W0: begin
        ra_d    = last_idx;
        state_d = ST_CMP0;
      end
      ST_CMP0: begin
        if (qry_q < rd_bp) begin
          res_h_d = rd_ang;
          res_k_d = KIND_BEFORE;
          state_d = ST_PUSH;
        end else begin
          bp_lo_d = rd_bp;
          a_lo_d  = rd_ang;
          ra_d    = AW'(1);
          state_d = ST_CMPL;
        end
      end
      ST_CMPL: begin
        ra_d = ra_q + AW'(1);
        if (qry_q >= rd_bp) begin
          res_h_d = rd_ang;
          res_k_d = KIND_AFTER;
          state_d = ST_PUSH;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // One entry per cycle; stop at the first breakpoint above the query
        if (qry_q < rd_bp) begin
          bp_hi_d = rd_bp;
          a_hi_d  = rd_ang;
          state_d = ST_PREP;
        end else begin
          bp_lo_d = rd_bp;
          a_lo_d  = rd_ang;
          ra_d    = ra_q + AW'(1);
        end
      end
      ST_PREP: begin
        if (dd_full[DISP_W] || (dd_full == '0)) begin
          res_h_d = a_lo_q;
          res_k_d = KIND_INTERP;
          state_d = ST_PUSH;
        end else begin
          dd_d    = dd_full[DISP_W-1:0];
          off_d   = off_full[DISP_W-1:0];
          dneg_d  = da[EXT_W-1];
          dmag_d  = da[EXT_W-1] ? MAG_W'(-da) : MAG_W'(da);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          tmag_d  = (MAG_W + 1)'(div_rsp.quo) + (MAG_W + 1)'(rnd_up);
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        res_h_d = hwrap[ANG_W-1:0];
        res_k_d = KIND_INTERP;
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        // Load the output register once it is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = res_h_q;
          m_kind_d  = res_k_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ra_q     <= ra_d;
    qry_q    <= qry_d;
    bp_lo_q  <= bp_lo_d;
    a_lo_q   <= a_lo_d;
    bp_hi_q  <= bp_hi_d;
    a_hi_q   <= a_hi_d;
    dd_q     <= dd_d;
    off_q    <= off_d;
    dmag_q   <= dmag_d;
    dneg_q   <= dneg_d;
    tmag_q   <= tmag_d;
    res_h_q  <= res_h_d;
    res_k_q  <= res_k_d;
    m_data_q <= m_data_d;
    m_kind_q <= m_kind_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;

endmodule

`default_nettype wire

@@ design/wapi_checker.sv @@
`default_nettype none
`include "wrapped_angle_profile_interp_top_assert.svh"

module wapi_checker
  import wapi_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 s_axis_tuser,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [KIND_W-1:0]    m_axis_tuser
);

  // Hold a stalled result
  `WAPI_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Too few entries always reports a zero heading
  `WAPI_ASSERT_IMP(a_few_zero, m_axis_tvalid && (m_axis_tuser == KIND_FEW), m_axis_tdata == '0)

  // A query transfer makes the block busy
  `WAPI_ASSERT_NXT(a_query_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_QUERY), !s_axis_tready)

  // A write transfer never raises a result
  `WAPI_ASSERT_NXT(a_write_quiet, s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_WRITE), !$rose(m_axis_tvalid))

endmodule

bind wrapped_angle_profile_interp_top wapi_checker u_wapi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

@@ verif/tb_wrapped_angle_profile_interp_top.sv @@
`default_nettype none

module tb_wrapped_angle_profile_interp_top;
  import wapi_pkg::*;

  localparam int SLOTS        = 16;
  localparam int HALF_TURN    = 25736;
  localparam int FULL_TURN    = 51472;
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEM_TARGET  = 1800;

  // One request as the sender sees it; unused fields carry noise
  typedef struct packed {
    logic              op;
    logic [3:0]        slot;
    logic [DISP_W-1:0] bp;
    logic [ANG_W-1:0]  ang;
    logic [DISP_W-1:0] qd;
  } profile_req_t;

  typedef struct packed {
    logic [ANG_W-1:0]  heading;
    logic [KIND_W-1:0] kind;
  } heading_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CNT_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = REQ_WRITE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;

  // Table copy as the block holds it, updated on accepted transfers
  logic signed [DISP_W-1:0] bp_mirror  [SLOTS];
  logic signed [ANG_W-1:0]  ang_mirror [SLOTS];
  // Table copy as the stimulus will leave it, updated when items are queued
  logic signed [DISP_W-1:0] gen_bp     [SLOTS];
  int                       entry_count_q = 0;

  profile_req_t pending_reqs[$];
  heading_t     pending_headings[$];
  profile_req_t cur_req;
  int           items_sent = 0;
  int           fail_count = 0;
  int           results_seen = 0;

  // Sender state
  int                   burst_left = 0;
  int                   gap_left = 0;
  logic                 take_next;
  logic [S_TDATA_W-1:0] nxt_data;

  // Receiver state
  rx_mode_e rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       rx_tick = 0;
  heading_t want;

  always #1 clk_i = ~clk_i;

  wrapped_angle_profile_interp_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Fold one turn back into [-pi, pi]
  function automatic int wrap_angle(input int a);
    if (a > HALF_TURN) return a - FULL_TURN;
    if (a < -HALF_TURN) return a + FULL_TURN;
    return a;
  endfunction

  // Heading at displacement q for the current table and entry count
  function automatic heading_t predict_heading(input logic signed [DISP_W-1:0] q);
    heading_t r;
    int       n;
    int       lo;
    int       hi;
    int       d;
    int       a_lo;
    int       h;
    longint   dd;
    longint   off;
    longint   num;
    longint   mag;
    longint   quo;
    n  = (entry_count_q > SLOTS) ? SLOTS : entry_count_q;
    lo = 0;
    hi = 0;
    if (n < 2) begin
      r.heading = '0;
      r.kind    = KIND_FEW;
    end else if (q < bp_mirror[0]) begin
      r.heading = ang_mirror[0];
      r.kind    = KIND_BEFORE;
    end else if (q >= bp_mirror[n-1]) begin
      r.heading = ang_mirror[n-1];
      r.kind    = KIND_AFTER;
    end else begin
      // first breakpoint above the query bounds the segment
      for (int i = 1; i < n; i++) begin
        if (hi == 0 && q < bp_mirror[i]) begin
          lo = i - 1;
          hi = i;
        end
      end
      a_lo = ang_mirror[lo];
      dd   = longint'(bp_mirror[hi]) - longint'(bp_mirror[lo]);
      if (dd <= 0) begin
        h = a_lo;
      end else begin
        d   = wrap_angle(int'(ang_mirror[hi]) - a_lo);
        off = longint'(q) - longint'(bp_mirror[lo]);
        num = longint'(d) * off;
        // round to nearest, ties away from zero
        mag = (num < 0) ? -num : num;
        quo = (2 * mag + dd) / (2 * dd);
        if (num < 0) quo = -quo;
        h = wrap_angle(int'(quo) + a_lo);
      end
      r.heading = h[ANG_W-1:0];
      r.kind    = KIND_INTERP;
    end
    return r;
  endfunction

  function automatic logic [ANG_W-1:0] rand_angle();
    int a;
    a = int'($urandom_range(0, FULL_TURN)) - HALF_TURN;
    return a[ANG_W-1:0];
  endfunction

  function automatic void push_write(input int slot, input logic [DISP_W-1:0] bp,
                                     input logic [ANG_W-1:0] ang);
    profile_req_t r;
    r.op   = REQ_WRITE;
    r.slot = slot[3:0];
    r.bp   = bp;
    r.ang  = ang;
    r.qd   = $urandom;
    gen_bp[slot] = bp;
    pending_reqs.push_back(r);
    items_sent++;
  endfunction

  function automatic void push_query(input logic [DISP_W-1:0] qd);
    profile_req_t r;
    r.op   = REQ_QUERY;
    r.slot = 4'($urandom_range(0, SLOTS - 1));
    r.bp   = $urandom;
    r.ang  = rand_angle();
    r.qd   = qd;
    pending_reqs.push_back(r);
    items_sent++;
  endfunction

  // Mostly queries inside the table span, some at breakpoints and extremes
  function automatic logic [DISP_W-1:0] pick_query();
    int                n;
    int                k;
    longint            span;
    longint unsigned   rnd;
    longint unsigned   ofs;
    logic [DISP_W-1:0] q;
    n = (entry_count_q > SLOTS) ? SLOTS : entry_count_q;
    q = $urandom;
    if (n >= 2) begin
      case ($urandom_range(0, 5))
        0: begin
          q = $urandom;
        end
        1, 2, 3: begin
          k    = $urandom_range(0, n - 2);
          span = longint'(gen_bp[k+1]) - longint'(gen_bp[k]);
          if (span > 0) begin
            rnd = {$urandom, $urandom};
            ofs = rnd % span;
            q   = gen_bp[k] + ofs[DISP_W-1:0];
          end else begin
            q = gen_bp[k];
          end
        end
        4: begin
          q = gen_bp[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
        end
        default: begin
          q = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      endcase
    end else if ($urandom_range(0, 3) == 0) begin
      q = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return q;
  endfunction

  // Fill all slots with a sorted table, wide or tightly spaced, in random slot order
  function automatic void load_sorted_table(input bit narrow);
    int vals[$];
    int order[$];
    int base;
    for (int i = 0; i < SLOTS; i++) order.push_back(i);
    if (narrow) begin
      base = int'($urandom) >>> 2;
      for (int i = 0; i < SLOTS; i++) begin
        vals.push_back(base);
        base = base + $urandom_range(1, 6);
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) vals.push_back(int'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        vals[0] = int'(32'h8000_0000);
        vals[1] = int'(32'h7FFF_FFFF);
      end
      vals.sort();
    end
    order.shuffle();
    foreach (order[i]) push_write(order[i], vals[order[i]], rand_angle());
  endfunction

  // Wait until every request is taken and every result is back, then let the block settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while ((pending_reqs.size() != 0 || s_axis_tvalid || pending_headings.size() != 0)
               && guard < 50000);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entry_count(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    entry_count_q = value;
  endtask

  // Sender: offer queued requests in bursts, predict on each accepted query
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= REQ_WRITE;
    end else begin
      take_next = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        take_next = 1'b1;
        if (cur_req.op == REQ_WRITE) begin
          bp_mirror[cur_req.slot]  = cur_req.bp;
          ang_mirror[cur_req.slot] = cur_req.ang;
        end else begin
          pending_headings.push_back(predict_heading(cur_req.qd));
        end
      end
      if (take_next) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req  = pending_reqs.pop_front();
          nxt_data = '0;
          nxt_data[OFS_IDX +: IDX_IN_W] = cur_req.slot;
          nxt_data[OFS_BP +: DISP_W]    = cur_req.bp;
          nxt_data[OFS_ANG +: ANG_W]    = cur_req.ang;
          nxt_data[OFS_QRY +: DISP_W]   = cur_req.qd;
          s_axis_tdata  <= nxt_data;
          s_axis_tuser  <= cur_req.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer, stall on a shifting pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_headings.size() == 0) begin
          $error("unexpected result transfer: heading %0d kind %0d",
                 $signed(m_axis_tdata), m_axis_tuser);
          fail_count++;
        end else begin
          want = pending_headings.pop_front();
          if (m_axis_tdata !== want.heading) begin
            $error("heading mismatch: expected %0d, actual %0d",
                   $signed(want.heading), $signed(m_axis_tdata));
            fail_count++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("result_kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser);
            fail_count++;
          end
        end
        // hold off for a long stretch now and then so the input backs up
        if (results_seen % 700 == 350) hold_left = 300;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= (rx_tick % 4 == 0);
          default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus phases; the entry count changes only while the block is idle
  initial begin
    int cnt;
    int n_items;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // too few entries, then a known sorted table
    write_entry_count(5'd0);
    push_query(32'h8000_0000);
    push_query(32'h7FFF_FFFF);
    for (int i = 0; i < SLOTS; i++) begin
      push_write(i, (i - 8) * 32'sh0800_0000,
                 (i % 2 == 0) ? 16'(HALF_TURN - i * 1500) : 16'(-HALF_TURN + i * 1300));
    end
    wait_drained();
    write_entry_count(5'd1);
    push_query('0);
    wait_drained();

    // full table: below, at and above the ends, a segment midpoint
    write_entry_count(5'd16);
    push_query(32'h8000_0000);
    push_query(gen_bp[0] - 1);
    push_query(gen_bp[0]);
    push_query(gen_bp[3] + 32'h0400_0000);
    push_query(gen_bp[15] - 1);
    push_query(gen_bp[15]);
    push_query(32'h7FFF_FFFF);
    wait_drained();

    // count above the table size saturates
    write_entry_count(5'd31);
    push_query(gen_bp[15]);
    push_query(gen_bp[7] + 1);
    wait_drained();
    write_entry_count(5'd2);
    push_query(gen_bp[0] + 5);
    push_query(gen_bp[1]);
    wait_drained();

    // random phases: mostly sorted tables queried inside their span
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = 2;
        3, 4:    cnt = SLOTS;
        5:       cnt = $urandom_range(SLOTS + 1, 31);
        default: cnt = $urandom_range(2, SLOTS);
      endcase
      write_entry_count(cnt[CNT_W-1:0]);
      if ($urandom_range(0, 3) != 0) load_sorted_table($urandom_range(0, 9) < 3);
      n_items = $urandom_range(20, 60);
      repeat (n_items) begin
        // stray writes leave the table unsorted
        if ($urandom_range(0, 11) == 0) begin
          push_write($urandom_range(0, SLOTS - 1), $urandom, rand_angle());
        end else begin
          push_query(pick_query());
        end
      end
      wait_drained();
    end

    if (pending_headings.size() != 0) begin
      $error("%0d expected results never arrived", pending_headings.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/wapi_pkg.sv
design/wapi_table.sv
design/wapi_div.sv
design/wrapped_angle_profile_interp_top.sv
design/wapi_checker.sv
verif/tb_wrapped_angle_profile_interp_top.sv
